@@ design/compass_heading_atan2_top_assert.svh @@
// assertion macros shared by the compass heading design
`ifndef COMPASS_HEADING_ATAN2_TOP_ASSERT_SVH
`define COMPASS_HEADING_ATAN2_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define CHS_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define CHS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ design/chs_pkg.sv @@
// shared types, constants and the arctangent table for the compass heading pipeline
package chs_pkg;

  // datapath width for x, y and the angle accumulator (degrees * 65536)
  localparam int W = 28;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int PADDR_W = 3;

  localparam logic signed [W-1:0] HALF_TURN = 28'sd11796480;
  localparam logic signed [W-1:0] FULL_TURN = 28'sd23592960;
  localparam logic [15:0] HEADING_MAX = 16'd46080;

  // register index of the declination register
  localparam logic REG_DECL = 1'b0;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic                zero;
  } cordic_t;

  // atan(2^-i) in degrees * 65536, rounded to nearest
  function automatic logic signed [W-1:0] atan_q16(input int i);
    logic signed [W-1:0] v;
    case (i)
      0:  v = 28'sd2949120;
      1:  v = 28'sd1740967;
      2:  v = 28'sd919879;
      3:  v = 28'sd466945;
      4:  v = 28'sd234379;
      5:  v = 28'sd117304;
      6:  v = 28'sd58666;
      7:  v = 28'sd29335;
      8:  v = 28'sd14668;
      9:  v = 28'sd7334;
      10: v = 28'sd3667;
      11: v = 28'sd1833;
      12: v = 28'sd917;
      13: v = 28'sd458;
      14: v = 28'sd229;
      15: v = 28'sd115;
      16: v = 28'sd57;
      17: v = 28'sd29;
      18: v = 28'sd14;
      19: v = 28'sd7;
      20: v = 28'sd4;
      21: v = 28'sd2;
      22: v = 28'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ design/compass_heading_atan2_top.sv @@
// top level of the compass heading pipeline: cordic atan2 of magnetometer x and y
//
//  channel | ports        | word contents (low bit up)
//  --------+--------------+-----------------------------------------------
//  input   | in_t*        | x_msb[7:0], x_lsb[15:8], y_msb[23:16], y_lsb[31:24]
//  output  | out_t*       | heading[15:0], degrees * 128
//  config  | cfg_p* (apb) | 0x0 declination, signed degrees * 128
//
// one word per cycle sustained while the output is not held; the stages are the input stage,
// one register per cordic iteration, then declination, first wrap pass, second wrap pass with rounding
// each stage holds its own valid bit and only stalls when it and everything after it
// is full, so bubbles are squeezed out under back pressure
// rst_n is synchronous; it empties the pipeline and clears the declination to zero
module compass_heading_atan2_top #(
  parameter int CORDIC_STAGES = chs_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // x_msb, x_lsb, y_msb, y_lsb
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // heading
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [chs_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int N = (CORDIC_STAGES > chs_pkg::ATAN_ENTRIES) ?
                     chs_pkg::ATAN_ENTRIES : CORDIC_STAGES;

  logic signed [15:0] decl_r, decl_nxt;
  logic cfg_wr;

  chs_pkg::cordic_t stg_data [N+1];
  logic             stg_valid [N+1];
  logic             stg_ready [N+1];

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == chs_pkg::REG_DECL);
  assign decl_nxt   = cfg_wr ? $signed(cfg_pwdata[15:0]) : decl_r;
  assign cfg_prdata = (cfg_paddr[2] == chs_pkg::REG_DECL) ? {16'b0, decl_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= '0;
    end else begin
      decl_r <= decl_nxt;
    end
  end

  chs_prerot u_prerot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .x_msb     (in_tdata[7:0]),
    .x_lsb     (in_tdata[15:8]),
    .y_msb     (in_tdata[23:16]),
    .y_lsb     (in_tdata[31:24]),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cordic
    chs_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  chs_wrap u_wrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .decl      (decl_r),
    .in_valid  (stg_valid[N]),
    .in_ready  (stg_ready[N]),
    .in_data   (stg_data[N]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .heading   (out_tdata)
  );

`include "compass_heading_atan2_top_assert.svh"

  // the result never leaves the 0..360 degree range
  `CHS_ASSERT_SAME(a_heading_range, clk, rst_n, out_tvalid, out_tdata <= chs_pkg::HEADING_MAX, "heading above 360 degrees")

  // a write to the declination register lands on the next edge
  `CHS_ASSERT_NEXT(a_decl_write, clk, rst_n, cfg_wr, decl_r == $past($signed(cfg_pwdata[15:0])), "declination write lost")

  // the input only stalls when the whole pipe is full and the output is held
  `CHS_ASSERT_SAME(a_stall_full, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input stalled with room in the pipe")

  // without a write the declination keeps its value
  `CHS_ASSERT_NEXT(a_decl_hold, clk, rst_n, !cfg_wr, $stable(decl_r), "declination changed without a write")

endmodule

@@ design/chs_prerot.sv @@
// input stage: joins the axis bytes, pre-rotates into the right half plane and scales
module chs_prerot (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       x_msb,
  input  logic [7:0]       x_lsb,
  input  logic [7:0]       y_msb,
  input  logic [7:0]       y_lsb,
  output logic             out_valid,
  input  logic             out_ready,
  output chs_pkg::cordic_t out_data
);

  logic signed [15:0] x_w, y_w;
  logic signed [chs_pkg::W-1:0] x_e, y_e, x_n, y_n, z_0;
  logic x_neg;
  logic valid_r, valid_nxt;
  chs_pkg::cordic_t data_r, data_nxt;

  assign x_w   = $signed({x_msb, x_lsb});
  assign y_w   = $signed({y_msb, y_lsb});
  assign x_e   = chs_pkg::W'(x_w);
  assign y_e   = chs_pkg::W'(y_w);
  assign x_neg = x_w < 16'sd0;

  always_comb begin
    x_n = x_neg ? -x_e : x_e;
    y_n = x_neg ? -y_e : y_e;
    if (!x_neg) begin
      z_0 = '0;
    end else if (y_w >= 16'sd0) begin
      z_0 = chs_pkg::HALF_TURN;
    end else begin
      z_0 = -chs_pkg::HALF_TURN;
    end
    data_nxt.x    = x_n <<< 8;
    data_nxt.y    = y_n <<< 8;
    data_nxt.z    = z_0;
    data_nxt.zero = (x_w == 16'sd0) && (y_w == 16'sd0);
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ design/chs_cordic_stage.sv @@
// one vectoring cordic iteration with its own pipeline register
module chs_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  chs_pkg::cordic_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output chs_pkg::cordic_t out_data
);

  localparam logic signed [chs_pkg::W-1:0] ANGLE = chs_pkg::atan_q16(SHIFT);

  logic signed [chs_pkg::W-1:0] xs, ys;
  logic valid_r, valid_nxt;
  chs_pkg::cordic_t data_r, data_nxt;

  assign xs = in_data.x >>> SHIFT;
  assign ys = in_data.y >>> SHIFT;

  always_comb begin
    data_nxt.zero = in_data.zero;
    // rotate towards y = 0, y of zero counts as positive
    if (in_data.y >= 0) begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z + ANGLE;
    end else begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z - ANGLE;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ design/chs_wrap.sv @@
// back end: declination add, two wrap passes into 0..360 and rounding to degrees * 128
module chs_wrap (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [15:0] decl,
  input  logic               in_valid,
  output logic               in_ready,
  input  chs_pkg::cordic_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        heading
);

  logic signed [chs_pkg::W-1:0] decl_q16, z_sel, sum_a, wrap_b, wrap_c, round_c;
  logic signed [chs_pkg::W-1:0] a_r, b_r;
  logic [15:0] c_r;
  logic va_r, vb_r, vc_r;
  logic rdy_a, rdy_b, rdy_c;

  assign decl_q16 = {{(chs_pkg::W-25){decl[15]}}, decl, 9'b0};
  assign z_sel    = in_data.zero ? '0 : in_data.z;
  assign sum_a    = z_sel + decl_q16;

  function automatic logic signed [chs_pkg::W-1:0] wrap1(input logic signed [chs_pkg::W-1:0] h);
    logic signed [chs_pkg::W-1:0] r;
    if (h < 0) begin
      r = h + chs_pkg::FULL_TURN;
    end else if (h > chs_pkg::FULL_TURN) begin
      r = h - chs_pkg::FULL_TURN;
    end else begin
      r = h;
    end
    return r;
  endfunction

  assign wrap_b  = wrap1(a_r);
  assign wrap_c  = wrap1(b_r);
  // round half up, value is known to lie in 0..360 here
  assign round_c = wrap_c + 28'sd256;

  assign rdy_c = !vc_r || out_ready;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) a_r <= sum_a;
    if (rdy_b && va_r)     b_r <= wrap_b;
    if (rdy_c && vb_r)     c_r <= round_c[24:9];
  end

  assign out_valid = vc_r;
  assign heading   = c_r;

endmodule

@@ test/compass_heading_atan2_checker.sv @@
// stream monitor and heading predictor for the compass heading pipeline
`timescale 1ns / 1ps

module compass_heading_atan2_checker #(
  parameter int STAGES = chs_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // x_msb, x_lsb, y_msb, y_lsb
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [15:0]                 out_tdata,  // heading
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [chs_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  input  logic                        cfg_pready,
  output int                          fail_count,
  output int                          pending
);

  localparam longint TURN_Q16 = 64'sd360 * 64'sd65536;
  localparam longint HALF_Q16 = 64'sd180 * 64'sd65536;
  localparam int     N_ITER   = (STAGES > 24) ? 24 : STAGES;

  // atan(2^-i) in degrees * 65536
  localparam longint ARCTAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic signed [15:0] decl_q7;
  logic [15:0]        heading_q[$];

  function automatic logic [15:0] predict_heading(input logic [31:0] word,
                                                  input logic signed [15:0] decl);
    logic signed [15:0] xw;
    logic signed [15:0] yw;
    longint x, y, z, xs, ys, h;
    xw = {word[7:0], word[15:8]};
    yw = {word[23:16], word[31:24]};
    x = xw;
    y = yw;
    z = 0;
    if (x != 0 || y != 0) begin
      // fold the left half plane onto the right one
      if (x < 0) begin
        z = (y >= 0) ? HALF_Q16 : -HALF_Q16;
        x = -x;
        y = -y;
      end
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < N_ITER; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN_Q16[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN_Q16[i];
        end
      end
    end
    h = z + longint'(decl) * 512;
    while (h < 0) h = h + TURN_Q16;
    while (h > TURN_Q16) h = h - TURN_Q16;
    h = (h + 256) >>> 9;
    return h[15:0];
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    decl_q7    = '0;
  end

  always @(posedge clk) begin : watch
    logic [15:0] want;
    if (!rst_n) begin
      decl_q7 = '0;
      heading_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[chs_pkg::PADDR_W-1:2] == chs_pkg::REG_DECL)
        decl_q7 = cfg_pwdata[15:0];
      if (in_tvalid && in_tready)
        heading_q.push_back(predict_heading(in_tdata, decl_q7));
      if (out_tvalid && out_tready) begin
        if (heading_q.size() == 0) begin
          $error("heading: no word expected, got %0d", out_tdata);
          fail_count++;
        end else begin
          want = heading_q.pop_front();
          if (out_tdata !== want) begin
            $error("heading mismatch: expected %0d, got %0d", want, out_tdata);
            fail_count++;
          end
        end
      end
    end
    pending = heading_q.size();
  end

endmodule

@@ test/compass_heading_atan2_top_tb.sv @@
// stimulus and verdict for the compass heading pipeline
`timescale 1ns / 1ps

module compass_heading_atan2_top_tb;

  localparam int STAGES      = chs_pkg::CORDIC_STAGES_DEF;
  localparam int DRAIN       = STAGES + 8;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 92;
  localparam logic [chs_pkg::PADDR_W-1:0] DECL_ADDR   = {chs_pkg::REG_DECL, 2'b00};
  localparam logic [chs_pkg::PADDR_W-1:0] UNUSED_ADDR = 3'd4;

  // corner vectors: zero, axes, diagonals, both sides of the branch cut
  localparam logic signed [15:0] DIR_X [16] = '{
    0, 32767, -32768, -32768, 0, 0, -1, 1,
    -32768, 32767, 32767, 0, -1, 1, 32767, -32768
  };
  localparam logic signed [15:0] DIR_Y [16] = '{
    0, 0, 0, -1, 32767, -32768, 0, 0,
    -32768, 32767, -32768, 1, -1, -1, -1, 32767
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [31:0]                  in_tdata;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [15:0]                  out_tdata;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [chs_pkg::PADDR_W-1:0]  cfg_paddr;
  logic [31:0]                  cfg_pwdata;
  logic [31:0]                  cfg_prdata;
  logic                         cfg_pready;
  int                           fail_count;
  int                           pending;
  bit                           jitter;

  compass_heading_atan2_top #(.CORDIC_STAGES(STAGES)) i_dut (.*);

  compass_heading_atan2_checker #(.STAGES(STAGES)) i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_pready, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stall bursts while jitter is on
  initial begin : drain
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && jitter && $urandom_range(0, 5) == 0)
        hold = $urandom_range(1, 11);
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  function automatic logic [31:0] pack_xy(input logic signed [15:0] x,
                                          input logic signed [15:0] y);
    return {y[7:0], y[15:8], x[7:0], x[15:8]};
  endfunction

  function automatic logic [31:0] random_word();
    logic signed [15:0] corner_vals [5];
    logic signed [15:0] x, y;
    int kind;
    corner_vals = '{-32768, -1, 0, 1, 32767};
    kind = $urandom_range(0, 9);
    x = 16'($urandom);
    y = 16'($urandom);
    case (kind)
      6, 7: begin
        x = 16'(int'($urandom_range(0, 8)) - 4);
        y = 16'(int'($urandom_range(0, 8)) - 4);
      end
      8: begin
        if ($urandom_range(0, 1)) x = '0;
        else y = '0;
      end
      9: begin
        x = corner_vals[$urandom_range(0, 4)];
        y = corner_vals[$urandom_range(0, 4)];
      end
      default: ;
    endcase
    return pack_xy(x, y);
  endfunction

  // returns at the falling edge after the word was taken, tvalid still high
  task automatic send_word(input logic [31:0] word);
    if (jitter && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [chs_pkg::PADDR_W-1:0] addr,
                           input logic [31:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  initial begin : stimulus
    logic signed [15:0] decl;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    jitter      = 1'b1;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    apb_write(DECL_ADDR, 32'd0);
    for (int i = 0; i < 16; i++) send_word(pack_xy(DIR_X[i], DIR_Y[i]));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: decl = 16'sd23040;
        1: decl = -16'sd23040;
        2: decl = 16'sd32767;
        3: decl = 16'sh8000;
        4: decl = 16'sd1;
        default: decl = 16'(int'($urandom_range(0, 46080)) - 23040);
      endcase
      apb_write(DECL_ADDR, {{16{decl[15]}}, decl});
      // index one holds no register: the write must leave the declination alone
      if (p == 4) apb_write(UNUSED_ADDR, $urandom);
      jitter = (p != 2) && (p != PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) send_word(random_word());
    end

    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/chs_pkg.sv
design/chs_prerot.sv
design/chs_cordic_stage.sv
design/chs_wrap.sv
design/compass_heading_atan2_top.sv
test/compass_heading_atan2_checker.sv
test/compass_heading_atan2_top_tb.sv
